### rtl/core/mbx_pkg.sv
// ----------------------------------------------------------------------------
// mbx_pkg
// Shared types, codes and defaults of the per-process message mailbox.
// ----------------------------------------------------------------------------
package mbx_pkg;

    localparam int CHANNEL_COUNT_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 8;
    localparam int MAX_MSG_BYTES_DEF = 8;

    localparam logic [3:0] QUEUE_LIMIT_RESET = 4'd8;

    typedef enum logic
    {
        FUNC_SEND = 1'b0,
        FUNC_RECV = 1'b1
    } mbx_func_t;

    typedef enum logic [1:0]
    {
        ST_OK      = 2'd0,
        ST_BAD_LEN = 2'd1,
        ST_NO_CHAN = 2'd2,
        ST_BUSY    = 2'd3
    } mbx_status_t;

    typedef struct packed
    {
        mbx_func_t   func;
        logic [7:0]  caller_pid;
        logic [7:0]  target_pid;
        logic [31:0] msg_type;
        logic [3:0]  msg_length;
        logic [63:0] payload;
    } mbx_item_t;

    typedef struct packed
    {
        mbx_status_t status;
        logic [7:0]  out_sender;
        logic [31:0] out_type;
        logic [3:0]  out_length;
        logic [63:0] out_payload;
        logic        wake_valid;
        logic [7:0]  wake_pid;
    } mbx_result_t;

    // One stored message slot
    typedef struct packed
    {
        logic [7:0]  sender;
        logic [31:0] msg_type;
        logic [3:0]  msg_length;
        logic [63:0] payload;
    } mbx_msg_t;

    // Zero the payload bytes at and above the given length
    function automatic logic [63:0] mask_payload(input logic [63:0] data,
                                                 input logic [3:0]  len);
        logic [63:0] res;
        res = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < len)
            begin
                res[8*b +: 8] = data[8*b +: 8];
            end
        end
        return res;
    endfunction

endpackage

### rtl/core/per_process_message_mailbox.sv
// ----------------------------------------------------------------------------
// per_process_message_mailbox
// Mailbox engine with one message ring per process channel. Channel owners
// sit in flops for a parallel lookup; ring state sits in a synchronous memory
// that is read, modified and written back, and messages in a second one.
// ----------------------------------------------------------------------------
//
//  channel   | ports                          | handshake
//  ----------+--------------------------------+------------------------------
//  command   | start, busy, cmd               | taken when start && !busy
//  result    | done, result                   | one-cycle strobe, no stall
//  config    | cfg_valid, cfg_ready, cfg_data | written when valid && ready
//
//  One item at a time. A command passes the owner compare register and the
//  priority pick; a bad length or no channel ends there. A send or an empty
//  receive then reads the channel memory, and a receive that pops a message
//  also reads the message memory. busy drops in the strobe cycle,
//  so the next command can be taken then. Reset frees every channel at once;
//  the memories need no clearing pass. The result side never stalls.
//
module per_process_message_mailbox
#(
    parameter int CHANNEL_COUNT = mbx_pkg::CHANNEL_COUNT_DEF,
    parameter int QUEUE_DEPTH   = mbx_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_MSG_BYTES = mbx_pkg::MAX_MSG_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mbx_pkg::mbx_item_t   cmd,
    output logic                 done,
    output mbx_pkg::mbx_result_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_data
);

    import mbx_pkg::*;

    localparam int CH_AW    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int SLOTS    = CHANNEL_COUNT * QUEUE_DEPTH;
    localparam int SLOT_AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HEAD_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int CTRL_W   = CNT_W + HEAD_W;

    localparam logic [3:0]        DEPTH_4   = 4'(QUEUE_DEPTH);
    localparam logic [3:0]        MAX_LEN_4 = 4'(MAX_MSG_BYTES);
    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(QUEUE_DEPTH - 1);

    typedef enum logic [4:0]
    {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_LOOKUP = 5'b00100,
        S_RMW    = 5'b01000,
        S_FETCH  = 5'b10000
    } state_t;

    // Control state
    state_t             state_reg, state_next;
    logic               done_reg, done_next;
    logic [7:0]         owner_reg [CHANNEL_COUNT];
    logic [3:0]         limit_reg;

    // Payload registers
    mbx_item_t          item_reg, item_next;
    logic [7:0]         pid_reg, pid_next;
    logic [CHANNEL_COUNT-1:0] hit_vec_reg, free_vec_reg;
    logic [CHANNEL_COUNT-1:0] hit_vec, free_vec;
    logic [CH_AW-1:0]   ch_reg, ch_next;
    logic               claim_reg, claim_next;
    mbx_result_t        result_reg, result_next;

    // Memories
    logic [CTRL_W-1:0]  ctrl_mem [CHANNEL_COUNT];
    logic [CTRL_W-1:0]  ctrl_q_reg;
    logic               ctrl_re, ctrl_we;
    logic [CH_AW-1:0]   ctrl_raddr;
    logic [CTRL_W-1:0]  ctrl_wdata;
    mbx_msg_t           msg_mem [SLOTS];
    mbx_msg_t           msg_q_reg;
    logic               msg_re, msg_we;
    logic [SLOT_AW-1:0] msg_addr;
    mbx_msg_t           msg_wdata;

    // Lookup and ring arithmetic
    logic               hit_any, free_any;
    logic [CH_AW-1:0]   hit_idx, free_idx;
    logic               owner_we;
    logic [CNT_W-1:0]   cnt_cur;
    logic [HEAD_W-1:0]  head_cur, head_inc, tail;
    logic [3:0]         ring_sum, limit_eff;
    logic [SLOT_AW-1:0] slot_base;
    logic               is_send;

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    assign is_send = (item_reg.func == FUNC_SEND);

    always_comb
    begin
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            hit_vec[i]  = (owner_reg[i] == pid_reg);
            free_vec[i] = (owner_reg[i] == 8'd0);
        end
    end

    // Lowest set bit wins in both vectors
    always_comb
    begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = CHANNEL_COUNT - 1; i >= 0; i--)
        begin
            if (hit_vec_reg[i])
            begin
                hit_any = 1'b1;
                hit_idx = CH_AW'(i);
            end
            if (free_vec_reg[i])
            begin
                free_any = 1'b1;
                free_idx = CH_AW'(i);
            end
        end
    end

    // A freshly claimed channel starts empty at slot zero
    assign cnt_cur   = claim_reg ? '0 : ctrl_q_reg[CTRL_W-1 -: CNT_W];
    assign head_cur  = claim_reg ? '0 : ctrl_q_reg[HEAD_W-1:0];
    assign head_inc  = (head_cur == HEAD_LAST) ? '0 : head_cur + HEAD_W'(1);
    assign ring_sum  = 4'(head_cur) + 4'(cnt_cur);
    assign tail      = (ring_sum >= DEPTH_4) ? HEAD_W'(ring_sum - DEPTH_4)
                                             : HEAD_W'(ring_sum);
    assign limit_eff = (limit_reg < DEPTH_4) ? limit_reg : DEPTH_4;
    assign slot_base = SLOT_AW'(ch_reg) * SLOT_AW'(QUEUE_DEPTH);
    assign msg_addr  = slot_base + SLOT_AW'(is_send ? tail : head_cur);

    always_comb
    begin
        mbx_result_t res;
        res = '0;

        state_next  = state_reg;
        done_next   = 1'b0;
        item_next   = item_reg;
        pid_next    = pid_reg;
        ch_next     = ch_reg;
        claim_next  = claim_reg;
        result_next = result_reg;
        owner_we    = 1'b0;
        ctrl_re     = 1'b0;
        ctrl_raddr  = hit_any ? hit_idx : free_idx;
        ctrl_we     = 1'b0;
        ctrl_wdata  = {cnt_cur, head_cur};
        msg_re      = 1'b0;
        msg_we      = 1'b0;
        msg_wdata.sender     = item_reg.caller_pid;
        msg_wdata.msg_type   = item_reg.msg_type;
        msg_wdata.msg_length = item_reg.msg_length;
        msg_wdata.payload    = mask_payload(item_reg.payload, item_reg.msg_length);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = cmd;
                    pid_next   = (cmd.func == FUNC_RECV) ? cmd.caller_pid
                                                         : cmd.target_pid;
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                state_next = S_LOOKUP;
            end

            S_LOOKUP:
            begin
                if (is_send && (item_reg.msg_length > MAX_LEN_4))
                begin
                    res.status  = ST_BAD_LEN;
                    result_next = res;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if ((pid_reg == 8'd0) || (!hit_any && !free_any))
                begin
                    res.status  = is_send ? ST_NO_CHAN : ST_BUSY;
                    result_next = res;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ch_next    = ctrl_raddr;
                    claim_next = !hit_any;
                    owner_we   = !hit_any;
                    ctrl_re    = 1'b1;
                    state_next = S_RMW;
                end
            end

            S_RMW:
            begin
                // Write back in every case so a claim always clears the ring
                ctrl_we = 1'b1;
                if (is_send)
                begin
                    if (4'(cnt_cur) >= limit_eff)
                    begin
                        res.status = ST_BUSY;
                    end
                    else
                    begin
                        msg_we         = 1'b1;
                        ctrl_wdata     = {cnt_cur + CNT_W'(1), head_cur};
                        res.status     = ST_OK;
                        res.wake_valid = 1'b1;
                        res.wake_pid   = item_reg.target_pid;
                    end
                    result_next = res;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (cnt_cur == '0)
                begin
                    res.status  = ST_BUSY;
                    result_next = res;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    msg_re     = 1'b1;
                    ctrl_wdata = {cnt_cur - CNT_W'(1), head_inc};
                    state_next = S_FETCH;
                end
            end

            S_FETCH:
            begin
                res.status      = ST_OK;
                res.out_sender  = msg_q_reg.sender;
                res.out_type    = msg_q_reg.msg_type;
                res.out_length  = msg_q_reg.msg_length;
                res.out_payload = msg_q_reg.payload;
                result_next     = res;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            limit_reg <= QUEUE_LIMIT_RESET;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                owner_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (owner_we)
            begin
                owner_reg[free_idx] <= pid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        pid_reg      <= pid_next;
        hit_vec_reg  <= hit_vec;
        free_vec_reg <= free_vec;
        ch_reg       <= ch_next;
        claim_reg    <= claim_next;
        result_reg   <= result_next;
    end

    // Ring state per channel: {count, head}
    always_ff @(posedge clk)
    begin
        if (ctrl_we)
        begin
            ctrl_mem[ch_reg] <= ctrl_wdata;
        end
        if (ctrl_re)
        begin
            ctrl_q_reg <= ctrl_mem[ctrl_raddr];
        end
    end

    // Message slots, QUEUE_DEPTH per channel
    always_ff @(posedge clk)
    begin
        if (msg_we)
        begin
            msg_mem[msg_addr] <= msg_wdata;
        end
        if (msg_re)
        begin
            msg_q_reg <= msg_mem[msg_addr];
        end
    end

`ifndef SYNTHESIS
    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while engine still working");

    a_fetch_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |=> (done_reg && (result_reg.status == ST_OK)))
        else $error("message fetch did not complete a receive");

    a_claim_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        owner_we |-> ((pid_reg != 8'd0) && free_vec_reg[free_idx]))
        else $error("channel claimed by pid zero or not free");

    a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.wake_valid) |->
            ((result_reg.status == ST_OK) && (result_reg.wake_pid != 8'd0)))
        else $error("wakeup without a successful send");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_SEARCH))
        else $error("accepted command did not start a lookup");
`endif

endmodule
